/* hw/rtl/rgk_pkg.sv */
`default_nettype none

package rgk_pkg;

   // Field widths
   localparam int ELEM_W   = 16;
   localparam int GAIN_W   = 24;
   localparam int KVAL_W   = 17;
   localparam int DIST_W   = 40;
   localparam int SQ_W     = 33;

   // Row queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Register indexes on the csr port
   localparam logic CSR_DISTANCE_GAIN = 1'b0;
   localparam logic CSR_RECUR_GAIN    = 1'b1;

   // Register reset values, Q8.16
   localparam logic [GAIN_W-1:0] DISTANCE_GAIN_RST = 24'd32768;
   localparam logic [GAIN_W-1:0] RECUR_GAIN_RST    = 24'd65536;

   // Arithmetic constants
   localparam logic [DIST_W-1:0] DIST_MAX   = 40'hFF_FFFF_FFFF;
   localparam logic [36:0]       ARG_CAP    = 37'h10_0000_0000;  // 16.0 in Q.32
   localparam logic [KVAL_W-1:0] ONE_Q16    = 17'h1_0000;
   localparam logic [3:0]        TAYLOR_LAST = 4'd12;
   localparam logic [2:0]        SQ_LAST     = 3'd4;              // five squarings

   // One finished row handed from front to back
   typedef struct packed {
      logic [DIST_W-1:0] row_dist;
      logic              seq_end;
   } rgk_row_type;

   // floor(2^32 / i) for the Taylor term divisors
   function automatic logic [31:0] rgk_recip(input logic [3:0] i);
      logic [31:0] m;
      begin
         unique case (i)
            4'd2:    m = 32'd2147483648;
            4'd3:    m = 32'd1431655765;
            4'd4:    m = 32'd1073741824;
            4'd5:    m = 32'd858993459;
            4'd6:    m = 32'd715827882;
            4'd7:    m = 32'd613566756;
            4'd8:    m = 32'd536870912;
            4'd9:    m = 32'd477218588;
            4'd10:   m = 32'd429496729;
            4'd11:   m = 32'd390451572;
            4'd12:   m = 32'd357913941;
            default: m = 32'd0;
         endcase
         return m;
      end
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/rgk_queue.sv */
`default_nettype none

module rgk_queue
   import rgk_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push_valid,
   output logic             push_ready,
   input  wire rgk_row_type push_data,
   output logic             pop_valid,
   input  wire logic        pop_ready,
   output rgk_row_type      pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   rgk_row_type      mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/rgk_front.sv */
`default_nettype none

module rgk_front
   import rgk_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic signed [ELEM_W-1:0] req_x_elem,
   input  wire logic signed [ELEM_W-1:0] req_y_elem,
   input  wire logic              req_last_in_row,
   input  wire logic              req_last_in_seq,
   output logic                   push_valid,
   input  wire logic              push_ready,
   output rgk_row_type            push_data
);

   // stage 1: squared difference
   logic              s1_valid_ff, s1_valid_in;
   logic [SQ_W-1:0]   s1_sq_ff, s1_sq_in;
   logic              s1_row_end_ff, s1_seq_end_ff;
   // stage 2: row accumulator
   logic [DIST_W-1:0] dist_acc_ff, dist_acc_in;

   logic signed [ELEM_W:0] diff;
   logic [ELEM_W:0]        mag;
   logic [2*ELEM_W+1:0]    sq_full;
   logic                   s1_end, s1_go, take;
   logic [DIST_W:0]        sum;
   logic [DIST_W-1:0]      sat;

   assign s1_end    = s1_row_end_ff || s1_seq_end_ff;
   assign s1_go     = s1_valid_ff && (!s1_end || push_ready);
   assign req_ready = !s1_valid_ff || s1_go;
   assign take      = req_valid && req_ready;

   // exact square of x - y
   always_comb begin
      diff    = (ELEM_W+1)'(req_x_elem) - (ELEM_W+1)'(req_y_elem);
      mag     = diff[ELEM_W] ? (ELEM_W+1)'(-diff) : (ELEM_W+1)'(diff);
      sq_full = {{(ELEM_W+1){1'b0}}, mag} * {{(ELEM_W+1){1'b0}}, mag};
      s1_sq_in    = sq_full[SQ_W-1:0];
      s1_valid_in = take || (s1_valid_ff && !s1_go);
   end

   // saturating accumulate, row handed over on its end
   always_comb begin
      sum         = {1'b0, dist_acc_ff} + (DIST_W+1)'(s1_sq_ff);
      sat         = (sum > {1'b0, DIST_MAX}) ? DIST_MAX : sum[DIST_W-1:0];
      push_valid  = s1_valid_ff && s1_end;
      push_data.row_dist = sat;
      push_data.seq_end  = s1_seq_end_ff;
      dist_acc_in = dist_acc_ff;
      if (s1_go) begin
         dist_acc_in = s1_end ? '0 : sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         dist_acc_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         dist_acc_ff <= dist_acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_sq_ff      <= s1_sq_in;
         s1_row_end_ff <= req_last_in_row;
         s1_seq_end_ff <= req_last_in_seq;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/rgk_back.sv */
`default_nettype none

module rgk_back
   import rgk_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [GAIN_W-1:0] distance_gain,
   input  wire logic [GAIN_W-1:0] recur_gain,
   input  wire logic              pop_valid,
   output logic                   pop_ready,
   input  wire rgk_row_type       pop_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [KVAL_W-1:0]      rsp_kernel_value
);

   typedef enum logic [11:0] {
      S_IDLE  = 12'b0000_0000_0001,
      S_T1LO  = 12'b0000_0000_0010,
      S_T1HI  = 12'b0000_0000_0100,
      S_T2    = 12'b0000_0000_1000,
      S_SUM   = 12'b0000_0001_0000,
      S_TMUL  = 12'b0000_0010_0000,
      S_TDIV  = 12'b0000_0100_0000,
      S_TFIX  = 12'b0000_1000_0000,
      S_DIFF  = 12'b0001_0000_0000,
      S_SQMUL = 12'b0010_0000_0000,
      S_SQ    = 12'b0100_0000_0000,
      S_RND   = 12'b1000_0000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic              seq_ff, seq_in;
   logic [63:0]       acc_ff, acc_in;
   logic [63:0]       mul_ff, mul_in;
   logic [31:0]       r_ff, r_in;
   logic [31:0]       term_ff, term_in;
   logic [31:0]       p_ff, p_in;
   logic [33:0]       pos_ff, pos_in;
   logic [32:0]       neg_ff, neg_in;
   logic [3:0]        idx_ff, idx_in;
   logic [31:0]       e_ff, e_in;
   logic [2:0]        sq_cnt_ff, sq_cnt_in;
   logic [KVAL_W-1:0] k_ff, k_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [KVAL_W-1:0] rsp_value_ff, rsp_value_in;

   logic [31:0] mul_a, mul_b;
   logic [36:0] t1c, a_arg;
   logic [41:0] arg_sum;
   logic [31:0] q0, term_next;
   logic [35:0] qi, rem;
   logic [33:0] e_diff;
   logic [32:0] rnd;
   logic [KVAL_W-1:0] k_new;

   assign pop_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kernel_value = rsp_value_ff;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_T1LO: begin
            mul_a = {12'b0, dist_ff[19:0]};
            mul_b = {8'b0, distance_gain};
         end
         S_T1HI: begin
            mul_a = {12'b0, dist_ff[39:20]};
            mul_b = {8'b0, distance_gain};
         end
         S_T2: begin
            mul_a = {15'b0, ONE_Q16 - k_ff};
            mul_b = {8'b0, recur_gain};
         end
         S_TMUL: begin
            mul_a = term_ff;
            mul_b = r_ff;
         end
         S_TDIV: begin
            mul_a = mul_ff[63:32];
            mul_b = rgk_recip(idx_ff);
         end
         S_SQMUL: begin
            mul_a = e_ff;
            mul_b = e_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_in = {32'b0, mul_a} * {32'b0, mul_b};
   end

   // datapath helpers
   always_comb begin
      // exponent argument, clamped to 16.0
      t1c     = (acc_ff > {27'b0, ARG_CAP}) ? ARG_CAP : acc_ff[36:0];
      arg_sum = {5'b0, t1c} + mul_ff[41:0];
      a_arg   = (arg_sum > {5'b0, ARG_CAP}) ? ARG_CAP : arg_sum[36:0];
      // reciprocal quotient, at most one short
      q0        = mul_ff[63:32];
      qi        = {4'b0, q0} * {32'b0, idx_ff};
      rem       = {4'b0, p_ff} - qi;
      term_next = q0 + 32'(rem >= {32'b0, idx_ff});
      e_diff    = pos_ff - {1'b0, neg_ff};
      rnd       = {1'b0, e_ff} + 33'h4000;
      k_new     = rnd[31:15];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      dist_in      = dist_ff;
      seq_in       = seq_ff;
      acc_in       = acc_ff;
      r_in         = r_ff;
      term_in      = term_ff;
      p_in         = p_ff;
      pos_in       = pos_ff;
      neg_in       = neg_ff;
      idx_in       = idx_ff;
      e_in         = e_ff;
      sq_cnt_in    = sq_cnt_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               dist_in  = pop_data.row_dist;
               seq_in   = pop_data.seq_end;
               state_in = S_T1LO;
            end
         end
         S_T1LO: state_in = S_T1HI;
         S_T1HI: begin
            acc_in   = mul_ff;
            state_in = S_T2;
         end
         S_T2: begin
            acc_in   = acc_ff + {mul_ff[43:0], 20'b0};
            state_in = S_SUM;
         end
         S_SUM: begin
            // first Taylor term is r itself
            r_in     = a_arg[36:5];
            term_in  = a_arg[36:5];
            neg_in   = {1'b0, a_arg[36:5]};
            pos_in   = 34'h1_0000_0000;
            idx_in   = 4'd2;
            state_in = S_TMUL;
         end
         S_TMUL: state_in = S_TDIV;
         S_TDIV: begin
            p_in     = mul_ff[63:32];
            state_in = S_TFIX;
         end
         S_TFIX: begin
            term_in = term_next;
            if (idx_ff[0]) begin
               neg_in = neg_ff + {1'b0, term_next};
            end else begin
               pos_in = pos_ff + {2'b0, term_next};
            end
            idx_in   = idx_ff + 1'b1;
            state_in = (idx_ff == TAYLOR_LAST) ? S_DIFF : S_TMUL;
         end
         S_DIFF: begin
            e_in      = e_diff[32:1];
            sq_cnt_in = '0;
            state_in  = S_SQMUL;
         end
         S_SQMUL: state_in = S_SQ;
         S_SQ: begin
            e_in      = mul_ff[62:31];
            sq_cnt_in = sq_cnt_ff + 1'b1;
            state_in  = (sq_cnt_ff == SQ_LAST) ? S_RND : S_SQMUL;
         end
         S_RND: begin
            if (!seq_ff) begin
               k_in     = k_new;
               state_in = S_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = k_new;
               k_in         = '0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff      <= dist_in;
      seq_ff       <= seq_in;
      acc_ff       <= acc_in;
      mul_ff       <= mul_in;
      r_ff         <= r_in;
      term_ff      <= term_in;
      p_ff         <= p_in;
      pos_ff       <= pos_in;
      neg_ff       <= neg_in;
      idx_ff       <= idx_in;
      e_ff         <= e_in;
      sq_cnt_ff    <= sq_cnt_in;
      rsp_value_ff <= rsp_value_in;
   end

endmodule

`default_nettype wire

/* hw/rtl/recursive_gaussian_kernel.sv */
// Path: an item ending a sequence passes the front stage register, the queue and the back
// sequencer before rsp_valid rises for it.
// Flow: one item per cycle within a row while the queue takes finished rows; each row end
// occupies the back and its shared 32x32 multiplier; QUEUE_DEPTH finished rows can wait for it.
// Reset: synchronous, active high; clears the row and kernel state, the queue and the
// result valid flag; distance_gain returns to 0.5 and recur_gain to 1.0.
`default_nettype none

module recursive_gaussian_kernel
   import rgk_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic signed [ELEM_W-1:0] req_x_elem,
   input  wire logic signed [ELEM_W-1:0] req_y_elem,
   input  wire logic                     req_last_in_row,
   input  wire logic                     req_last_in_seq,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [KVAL_W-1:0]             rsp_kernel_value,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic                     csr_index,
   input  wire logic [GAIN_W-1:0]        csr_data
);

   logic [GAIN_W-1:0] distance_gain_ff, distance_gain_in;
   logic [GAIN_W-1:0] recur_gain_ff, recur_gain_in;

   logic        push_valid, push_ready, pop_valid, pop_ready;
   rgk_row_type push_data, pop_data;

   // configuration registers, always ready
   assign csr_ready = 1'b1;

   always_comb begin
      distance_gain_in = distance_gain_ff;
      recur_gain_in    = recur_gain_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DISTANCE_GAIN: distance_gain_in = csr_data;
            CSR_RECUR_GAIN:    recur_gain_in    = csr_data;
            default:           distance_gain_in = distance_gain_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         distance_gain_ff <= DISTANCE_GAIN_RST;
         recur_gain_ff    <= RECUR_GAIN_RST;
      end else begin
         distance_gain_ff <= distance_gain_in;
         recur_gain_ff    <= recur_gain_in;
      end
   end

   rgk_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_x_elem      (req_x_elem),
      .req_y_elem      (req_y_elem),
      .req_last_in_row (req_last_in_row),
      .req_last_in_seq (req_last_in_seq),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_data       (push_data)
   );

   rgk_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   rgk_back u_back (
      .clock            (clock),
      .reset            (reset),
      .distance_gain    (distance_gain_ff),
      .recur_gain       (recur_gain_ff),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_data         (pop_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kernel_value (rsp_kernel_value)
   );

endmodule

`default_nettype wire
